// ===== src/sei_pkg.sv =====
// Package: microcode word, step and condition codes, status codes, insert program ROM.
package sei_pkg;

    localparam int KEY_W   = 11;
    localparam int STEP_W  = 4;
    localparam int COND_W  = 3;
    localparam logic [6:0] DEFAULT_LIMIT = 7'd40;

    // Result status codes
    localparam logic [1:0] ST_STORED = 2'd0;
    localparam logic [1:0] ST_DUP    = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    // Sequencer steps
    localparam logic [STEP_W-1:0] S_IDLE  = 4'd0;
    localparam logic [STEP_W-1:0] S_CHK   = 4'd1;
    localparam logic [STEP_W-1:0] S_RD    = 4'd2;
    localparam logic [STEP_W-1:0] S_CMP   = 4'd3;
    localparam logic [STEP_W-1:0] S_DEC   = 4'd4;
    localparam logic [STEP_W-1:0] S_SHRD  = 4'd5;
    localparam logic [STEP_W-1:0] S_SHWR  = 4'd6;
    localparam logic [STEP_W-1:0] S_WR    = 4'd7;
    localparam logic [STEP_W-1:0] S_DONE  = 4'd8;

    // Jump conditions
    localparam logic [COND_W-1:0] C_ALWAYS    = 3'd0;
    localparam logic [COND_W-1:0] C_VALID     = 3'd1;
    localparam logic [COND_W-1:0] C_FULL      = 3'd2;
    localparam logic [COND_W-1:0] C_SCAN_END  = 3'd3;
    localparam logic [COND_W-1:0] C_HIT       = 3'd4;
    localparam logic [COND_W-1:0] C_DUP       = 3'd5;
    localparam logic [COND_W-1:0] C_SHIFT_END = 3'd6;
    localparam logic [COND_W-1:0] C_OUT_FREE  = 3'd7;

    typedef struct packed {
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] jmp;
        logic [STEP_W-1:0] nxt;
        logic              in_ready;
        logic              ld_key;
        logic              chk_full;
        logic              set_pos;
        logic              inc_j;
        logic              ld_dup;
        logic              j_cnt;
        logic              rd_en;
        logic              rd_prev;
        logic              wr_en;
        logic              wr_key;
        logic              dec_j;
        logic              inc_cnt;
        logic              ld_out;
    } t_uword;

    function automatic t_uword uprog(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '0;
        case (step)
            S_IDLE: begin
                w.cond = C_VALID;    w.jmp = S_CHK;  w.nxt = S_IDLE;
                w.in_ready = 1'b1;   w.ld_key = 1'b1;
            end
            S_CHK: begin
                w.cond = C_FULL;     w.jmp = S_DONE; w.nxt = S_RD;
                w.chk_full = 1'b1;
            end
            S_RD: begin
                w.cond = C_SCAN_END; w.jmp = S_SHRD; w.nxt = S_CMP;
                w.set_pos = 1'b1;    w.rd_en = 1'b1;
            end
            S_CMP: begin
                w.cond = C_HIT;      w.jmp = S_DEC;  w.nxt = S_RD;
                w.set_pos = 1'b1;    w.inc_j = 1'b1; w.ld_dup = 1'b1;
            end
            S_DEC: begin
                w.cond = C_DUP;      w.jmp = S_DONE; w.nxt = S_SHRD;
                w.j_cnt = 1'b1;
            end
            S_SHRD: begin
                w.cond = C_SHIFT_END; w.jmp = S_WR;  w.nxt = S_SHWR;
                w.rd_en = 1'b1;      w.rd_prev = 1'b1;
            end
            S_SHWR: begin
                w.cond = C_ALWAYS;   w.jmp = S_SHRD; w.nxt = S_SHRD;
                w.wr_en = 1'b1;      w.dec_j = 1'b1;
            end
            S_WR: begin
                w.cond = C_ALWAYS;   w.jmp = S_DONE; w.nxt = S_DONE;
                w.wr_en = 1'b1;      w.wr_key = 1'b1; w.inc_cnt = 1'b1;
            end
            S_DONE: begin
                w.cond = C_OUT_FREE; w.jmp = S_IDLE; w.nxt = S_DONE;
                w.ld_out = 1'b1;
            end
            default: begin
                w.cond = C_ALWAYS;   w.jmp = S_IDLE; w.nxt = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== src/sorted_event_insert_core.sv =====
// Sorted alarm-time table: microcoded scan / shift / insert sequencer.
// Steps: IDLE accepts, CHK tests full, RD / CMP scan for the first entry not
//   earlier, DEC tests duplicate, SHRD / SHWR shift entries up, WR writes the key,
//   DONE loads the result once the output is free. One request in flight; the
//   table does one read or one write a cycle. Reset (sync, active low) clears count,
//   control and limit (40); table contents stay undefined, never read unwritten.
module sorted_event_insert_core #(
    parameter int CAPACITY = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Request channel
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [3:0]                i_hour,
    input  logic [5:0]                i_minute,
    input  logic                      i_pm,
    // Result channel
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [1:0]                o_status,
    output logic [5:0]                o_slot,
    output logic [6:0]                o_stored_count,
    // Register port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import sei_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // table index
    localparam int CW = $clog2(CAPACITY + 1);                   // count / scan index
    localparam int LW = (CW > 7) ? CW : 7;                      // limit compare width

    // Sequencer
    logic [STEP_W-1:0] r_step, n_step;
    t_uword            uw;
    logic              taken;

    // Datapath registers
    logic [KEY_W-1:0]  r_key;
    logic [KEY_W-1:0]  r_rd_data;
    logic [CW-1:0]     r_j;
    logic [CW-1:0]     r_pos;
    logic [CW-1:0]     r_cnt;
    logic              r_full;
    logic              r_dup;
    logic [6:0]        r_limit;

    // Output register
    logic              r_out_valid;
    logic [1:0]        r_out_status;
    logic [5:0]        r_out_slot;
    logic [6:0]        r_out_count;

    // Table storage, one read and one write port
    logic [KEY_W-1:0]  r_mem [CAPACITY];

    logic [LW-1:0]     lim_eff;
    logic              is_full;
    logic              out_free;
    logic [CW-1:0]     rd_idx;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [KEY_W-1:0]  wr_data;
    logic              cfg_wr;

    // ---------------- control ----------------
    assign uw       = uprog(r_step);
    assign out_free = !r_out_valid || i_ready;

    // Effective limit is min(event_limit, CAPACITY)
    assign lim_eff = (LW'(r_limit) < LW'(CAPACITY)) ? LW'(r_limit) : LW'(CAPACITY);
    assign is_full = LW'(r_cnt) >= lim_eff;

    always_comb begin
        case (uw.cond)
            C_ALWAYS:    taken = 1'b1;
            C_VALID:     taken = i_valid;
            C_FULL:      taken = is_full;
            C_SCAN_END:  taken = (r_j == r_cnt);
            C_HIT:       taken = (r_rd_data >= r_key);   // first entry not earlier
            C_DUP:       taken = r_dup;
            C_SHIFT_END: taken = (r_j == r_pos);
            C_OUT_FREE:  taken = out_free;
            default:     taken = 1'b1;
        endcase
        n_step = taken ? uw.jmp : uw.nxt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ready = uw.in_ready;

    // ---------------- datapath ----------------
    assign rd_idx  = uw.rd_prev ? (r_j - CW'(1)) : r_j;
    assign rd_addr = AW'(rd_idx);
    assign wr_addr = uw.wr_key ? AW'(r_pos) : AW'(r_j);
    assign wr_data = uw.wr_key ? r_key : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (uw.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (uw.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_j    <= '0;
            r_pos  <= '0;
            r_full <= 1'b0;
            r_dup  <= 1'b0;
        end else begin
            // New request: packed key pm:hour:minute, scan from slot 0
            if (uw.ld_key && i_valid) begin
                r_key <= {i_pm, i_hour, i_minute};
                r_j   <= '0;
                r_dup <= 1'b0;
            end
            if (uw.chk_full) begin
                r_full <= is_full;
            end
            // pos tracks the entry under test; at scan end it equals count
            if (uw.set_pos) begin
                r_pos <= r_j;
            end
            if (uw.ld_dup) begin
                r_dup <= (r_rd_data == r_key);
            end
            if (uw.inc_j) begin
                r_j <= r_j + CW'(1);
            end
            // Shift walks down from the top entry, index count
            if (uw.j_cnt) begin
                r_j <= r_cnt;
            end
            if (uw.dec_j) begin
                r_j <= r_j - CW'(1);
            end
            if (uw.inc_cnt) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    // ---------------- result ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (uw.ld_out && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.ld_out && out_free) begin
            r_out_status <= r_full ? ST_FULL : (r_dup ? ST_DUP : ST_STORED);
            r_out_slot   <= r_full ? 6'd0 : 6'(r_pos);
            r_out_count  <= 7'(r_cnt);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_slot         = r_out_slot;
    assign o_stored_count = r_out_count;

    // ---------------- register port ----------------
    // event_limit at byte addresses 0-3 (paddr[2] low); addresses 4-7 read zero, ignore writes
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= DEFAULT_LIMIT;
        end else if (cfg_wr) begin
            r_limit <= pwdata[6:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : 32'(r_limit);

endmodule
